>>> rtl/tli_pkg.sv
// Shared constants and types for the table linear interpolator.
package tli_pkg;

    localparam int unsigned TABLE_DEPTH = 64;
    localparam int unsigned DATA_WIDTH  = 16;

    localparam int unsigned ADDR_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned INDEX_W   = 6;
    localparam int unsigned PIU_W     = 7;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned REGION_W  = 2;
    localparam int unsigned SCAN_MAX  = (TABLE_DEPTH < 127) ? TABLE_DEPTH : 127;
    localparam int unsigned DIV_CNT_W = $clog2(DATA_WIDTH);

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_POINTS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BELOW_VALUE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ABOVE_VALUE   = 2'd2;

    localparam logic [REGION_W-1:0] REGION_INTERP = 2'd0;
    localparam logic [REGION_W-1:0] REGION_BELOW  = 2'd1;
    localparam logic [REGION_W-1:0] REGION_ABOVE  = 2'd2;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] x;
        logic [DATA_WIDTH-1:0] y;
    } point_t;

endpackage

>>> rtl/tli_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tli_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/table_linear_interpolator.sv
// Top level: breakpoint table, scan sequencer, multiplier and serial divider.
// Load beat: accepted while idle, no result.
// Query beat: a table read, a scan of one entry per cycle, a multiply and a serial
//   division, then a staging state that waits for the output stage; an out-of-range result
//   skips the multiply and division. No new beat is taken until the result is staged.
// Reset clears the control state and configuration registers; datapath registers and table contents stay undefined.
module table_linear_interpolator (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    action,
    input  logic [tli_pkg::INDEX_W-1:0]             point_index,
    input  logic signed [tli_pkg::DATA_WIDTH-1:0]   point_x,
    input  logic signed [tli_pkg::DATA_WIDTH-1:0]   point_y,
    input  logic signed [tli_pkg::DATA_WIDTH-1:0]   query_value,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [tli_pkg::DATA_WIDTH-1:0]   result_value,
    output logic [tli_pkg::REGION_W-1:0]            region,
    input  logic                                    cfg_we,
    input  logic [tli_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [tli_pkg::DATA_WIDTH-1:0]          cfg_wdata
);

    import tli_pkg::*;

    localparam int unsigned DW = DATA_WIDTH;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       mul_reg, mul_next;

    logic [PIU_W-1:0]  piu_reg;
    logic [DW-1:0]     below_reg;
    logic [DW-1:0]     above_reg;

    logic [PIU_W-1:0]  n_reg, n_next;
    logic [PIU_W-1:0]  issue_reg, issue_next;
    logic [PIU_W-1:0]  chk_idx_reg, chk_idx_next;
    logic              chk_valid_reg, chk_valid_next;
    logic signed [DW-1:0] q_reg, q_next;
    point_t            prev_reg, prev_next;

    logic [DW-1:0]     y0_reg, y0_next;
    logic [DW-1:0]     dx_reg, dx_next;
    logic [DW-1:0]     dv_reg, dv_next;
    logic [DW-1:0]     mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [DW-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]     res_reg, res_next;
    logic [REGION_W-1:0] reg_code_reg, reg_code_next;

    logic              out_valid_reg, out_valid_next;
    logic [DW-1:0]     out_res_reg, out_res_next;
    logic [REGION_W-1:0] out_region_reg, out_region_next;

    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    point_t            ram_wdata;
    point_t            rd_pt;
    logic [2*DW-1:0]   rd_raw;

    logic signed [DW-1:0] rd_x, rd_y, p_x, p_y;
    logic signed [DW:0]   dx_full, dv_full, dy_full, mag_full;
    logic [2*DW-1:0]      prod;
    logic [DW:0]          shifted, diff;
    logic                 ge;
    logic signed [DW:0]   fin_full;
    logic                 load_ok;
    logic                 out_load;

    // ---- table memory ----
    assign load_ok   = (32'(point_index) < TABLE_DEPTH);
    assign ram_we    = in_valid && in_ready && (action == ACT_LOAD) && load_ok;
    assign ram_wdata = '{x: point_x, y: point_y};
    assign ram_re    = (state_reg == ST_SCAN) && (issue_reg < n_reg);
    assign ram_raddr = ADDR_W'(issue_reg);

    tli_ram #(
        .WIDTH (2 * DW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(point_index)),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_raw)
    );

    assign rd_pt = rd_raw;
    assign rd_x  = rd_pt.x;
    assign rd_y  = rd_pt.y;
    assign p_x   = prev_reg.x;
    assign p_y   = prev_reg.y;

    // ---- segment arithmetic ----
    assign dx_full  = {rd_x[DW-1], rd_x} - {p_x[DW-1], p_x};
    assign dv_full  = {q_reg[DW-1], q_reg} - {p_x[DW-1], p_x};
    assign dy_full  = {rd_y[DW-1], rd_y} - {p_y[DW-1], p_y};
    assign mag_full = dy_full[DW] ? -dy_full : dy_full;

    assign prod    = {{DW{1'b0}}, mag_reg} * {{DW{1'b0}}, dv_reg};
    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign diff    = shifted - {1'b0, dx_reg};
    assign ge      = (shifted >= {1'b0, dx_reg});

    assign fin_full = neg_reg ? ($signed({y0_reg[DW-1], y0_reg}) - $signed({1'b0, quo_reg}))
                              : ($signed({y0_reg[DW-1], y0_reg}) + $signed({1'b0, quo_reg}));

    assign in_ready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        mul_next       = 1'b0;
        n_next         = n_reg;
        issue_next     = issue_reg;
        chk_idx_next   = chk_idx_reg;
        chk_valid_next = 1'b0;
        q_next         = q_reg;
        prev_next      = prev_reg;
        y0_next        = y0_reg;
        dx_next        = dx_reg;
        dv_next        = dv_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        reg_code_next  = reg_code_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (action == ACT_QUERY))
                begin
                    q_next     = query_value;
                    issue_next = '0;
                    n_next     = (piu_reg > PIU_W'(SCAN_MAX)) ? PIU_W'(SCAN_MAX) : piu_reg;
                    if (piu_reg == '0)
                    begin
                        res_next      = above_reg;
                        reg_code_next = REGION_ABOVE;
                        state_next    = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (ram_re)
                begin
                    issue_next     = issue_reg + 1'b1;
                    chk_idx_next   = issue_reg;
                    chk_valid_next = 1'b1;
                end
                if (chk_valid_reg)
                begin
                    prev_next = rd_pt;
                    if (q_reg < rd_x)
                    begin
                        chk_valid_next = 1'b0;
                        if (chk_idx_reg == '0)
                        begin
                            res_next      = below_reg;
                            reg_code_next = REGION_BELOW;
                            state_next    = ST_FIN;
                        end
                        else
                        begin
                            y0_next       = prev_reg.y;
                            dx_next       = dx_full[DW-1:0];
                            dv_next       = dv_full[DW-1:0];
                            mag_next      = mag_full[DW-1:0];
                            neg_next      = dy_full[DW];
                            reg_code_next = REGION_INTERP;
                            mul_next      = 1'b1;
                            cnt_next      = DIV_CNT_W'(DW - 1);
                            state_next    = ST_DIV;
                        end
                    end
                    else if (chk_idx_reg + 1'b1 == n_reg)
                    begin
                        chk_valid_next = 1'b0;
                        res_next       = above_reg;
                        reg_code_next  = REGION_ABOVE;
                        state_next     = ST_FIN;
                    end
                end
            end
            ST_DIV:
            begin
                if (mul_reg)
                begin
                    rem_next = prod[2*DW-1:DW];
                    quo_next = prod[DW-1:0];
                end
                else
                begin
                    rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
                    quo_next = {quo_reg[DW-2:0], ge};
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        out_region_next = out_region_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_region_next = reg_code_reg;
            out_res_next    = (reg_code_reg == REGION_INTERP) ? fin_full[DW-1:0] : res_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mul_reg       <= 1'b0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            piu_reg       <= '0;
            below_reg     <= '0;
            above_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mul_reg       <= mul_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_POINTS_IN_USE: piu_reg   <= cfg_wdata[PIU_W-1:0];
                    REG_BELOW_VALUE:   below_reg <= cfg_wdata;
                    REG_ABOVE_VALUE:   above_reg <= cfg_wdata;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        issue_reg      <= issue_next;
        chk_idx_reg    <= chk_idx_next;
        q_reg          <= q_next;
        prev_reg       <= prev_next;
        y0_reg         <= y0_next;
        dx_reg         <= dx_next;
        dv_reg         <= dv_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        cnt_reg        <= cnt_next;
        res_reg        <= res_next;
        reg_code_reg   <= reg_code_next;
        out_res_reg    <= out_res_next;
        out_region_reg <= out_region_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = out_res_reg;
    assign region       = out_region_reg;

`ifndef SYNTHESIS
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (action == ACT_QUERY) |=> !in_ready)
        else $error("query beat accepted without leaving idle");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE) && !ram_re)
        else $error("table write during a scan");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) && !mul_reg |-> (rem_reg < dx_reg))
        else $error("divider remainder out of range");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) && out_valid_reg && !out_ready |=> (state_reg == ST_FIN))
        else $error("result dropped while output stage full");
`endif

endmodule

>>> sim/table_linear_interpolator_test.sv
// Testbench for the table linear interpolator: directed and random beats against a predictor.
`timescale 1ns / 100ps

module table_linear_interpolator_test;
    import tli_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 120;
    localparam int IDLE_PCT      = 25;
    localparam int PRINT_CAP     = 100;
    localparam int WORD_MIN      = -32768;
    localparam int WORD_MAX      = 32767;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic                         action;
        logic [INDEX_W-1:0]           index;
        logic signed [DATA_WIDTH-1:0] x;
        logic signed [DATA_WIDTH-1:0] y;
        logic signed [DATA_WIDTH-1:0] q;
    } beat_t;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] value;
        logic [REGION_W-1:0]          region;
    } answer_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic                         action;
    logic [INDEX_W-1:0]           point_index;
    logic signed [DATA_WIDTH-1:0] point_x;
    logic signed [DATA_WIDTH-1:0] point_y;
    logic signed [DATA_WIDTH-1:0] query_value;
    logic                         out_valid;
    logic                         out_ready;
    logic signed [DATA_WIDTH-1:0] result_value;
    logic [REGION_W-1:0]          region;
    logic                         cfg_we;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [DATA_WIDTH-1:0]        cfg_wdata;

    beat_t   pending_beats[$];
    answer_t expected_answers[$];

    logic signed [DATA_WIDTH-1:0] curve_x[TABLE_DEPTH];
    logic signed [DATA_WIDTH-1:0] curve_y[TABLE_DEPTH];
    logic [PIU_W-1:0]             points_cfg;
    logic signed [DATA_WIDTH-1:0] below_cfg;
    logic signed [DATA_WIDTH-1:0] above_cfg;

    int  shadow_x[TABLE_DEPTH];
    int  span_lo;
    int  span_hi;
    int  points_live;

    int  errors;
    int  cycles;
    int  loads_taken;
    int  queries_taken;
    int  region_hits[3];
    bit  steady;
    bit  in_fire;

    table_linear_interpolator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .point_index  (point_index),
        .point_x      (point_x),
        .point_y      (point_y),
        .query_value  (query_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .region       (region),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    task automatic report_mismatch(string msg);
        if (errors < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    function automatic answer_t interpolate(logic signed [DATA_WIDTH-1:0] q);
        answer_t ans;
        int      n;
        longint  x0, x1, y0, y1, dy, mag, quo, res;
        ans.value  = above_cfg;
        ans.region = REGION_ABOVE;
        n = (points_cfg < TABLE_DEPTH) ? points_cfg : TABLE_DEPTH;
        for (int i = 0; i < n; i++)
        begin
            if (q < curve_x[i])
            begin
                if (i == 0)
                begin
                    ans.value  = below_cfg;
                    ans.region = REGION_BELOW;
                end
                else
                begin
                    x0  = curve_x[i-1];
                    x1  = curve_x[i];
                    y0  = curve_y[i-1];
                    y1  = curve_y[i];
                    dy  = y1 - y0;
                    mag = (dy < 0) ? -dy : dy;
                    quo = (mag * (q - x0)) / (x1 - x0);
                    res = (dy < 0) ? y0 - quo : y0 + quo;
                    ans.value  = res[DATA_WIDTH-1:0];
                    ans.region = REGION_INTERP;
                end
                return ans;
            end
        end
        return ans;
    endfunction

    always @(posedge clk)
    begin : monitor
        answer_t want;
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_answers.size());
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            in_fire <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                if (action == ACT_LOAD)
                begin
                    curve_x[point_index] = point_x;
                    curve_y[point_index] = point_y;
                    loads_taken++;
                end
                else
                begin
                    expected_answers.push_back(interpolate(query_value));
                    queries_taken++;
                end
            end
            if (out_valid && out_ready)
            begin
                if (expected_answers.size() == 0)
                    report_mismatch($sformatf("result beat %0d/%0d with nothing expected",
                                              result_value, region));
                else
                begin
                    want = expected_answers.pop_front();
                    if (result_value !== want.value)
                        report_mismatch($sformatf("result_value %0d, expected %0d",
                                                  result_value, want.value));
                    if (region !== want.region)
                        report_mismatch($sformatf("region %0d, expected %0d",
                                                  region, want.region));
                    if (want.region <= REGION_ABOVE)
                        region_hits[want.region]++;
                end
            end
        end
    end

    always @(negedge clk)
    begin : driver
        beat_t nxt;
        if (rst_n)
        begin
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            if (!in_valid || in_fire)
            begin
                if (pending_beats.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = pending_beats.pop_front();
                    in_valid    <= 1'b1;
                    action      <= nxt.action;
                    point_index <= nxt.index;
                    point_x     <= nxt.x;
                    point_y     <= nxt.y;
                    query_value <= nxt.q;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    function automatic int clamp_word(int v);
        return (v < WORD_MIN) ? WORD_MIN : ((v > WORD_MAX) ? WORD_MAX : v);
    endfunction

    function automatic int random_word();
        return $urandom_range(WORD_MAX, 0) - $urandom_range(1, 0) * 32768;
    endfunction

    task automatic push_load(int idx, int x, int y);
        beat_t b;
        b.action = ACT_LOAD;
        b.index  = INDEX_W'(idx);
        b.x      = DATA_WIDTH'(x);
        b.y      = DATA_WIDTH'(y);
        b.q      = DATA_WIDTH'($urandom);
        shadow_x[idx] = x;
        pending_beats.push_back(b);
    endtask

    task automatic push_query(int q);
        beat_t b;
        b.action = ACT_QUERY;
        b.index  = INDEX_W'($urandom);
        b.x      = DATA_WIDTH'($urandom);
        b.y      = DATA_WIDTH'($urandom);
        b.q      = DATA_WIDTH'(q);
        pending_beats.push_back(b);
    endtask

    task automatic drain();
        while (pending_beats.size() != 0 || in_valid || expected_answers.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= DATA_WIDTH'(val);
        case (idx)
            REG_POINTS_IN_USE: points_cfg = PIU_W'(val);
            REG_BELOW_VALUE:   below_cfg  = DATA_WIDTH'(val);
            REG_ABOVE_VALUE:   above_cfg  = DATA_WIDTH'(val);
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic build_table(int n, int lo, int hi, bit extreme_y);
        int x;
        int stride;
        stride = (n > 0) ? (hi - lo) / n : 1;
        if (stride < 1)
            stride = 1;
        x = lo;
        span_hi = lo;
        for (int i = 0; i < n; i++)
        begin
            push_load(i, x, extreme_y ? ((i % 2) ? WORD_MAX : WORD_MIN) : random_word());
            span_hi = x;
            x = clamp_word(x + $urandom_range(stride, (i % 7 == 3) ? 0 : 1));
        end
        span_lo = lo;
        points_live = n;
    endtask

    task automatic mix_beats(int count);
        int pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                push_load($urandom_range(TABLE_DEPTH - 1), random_word(), random_word());
            else if (pick < 20)
                push_query(random_word());
            else if (pick < 32 && points_live > 0)
                push_query(clamp_word(shadow_x[$urandom_range(points_live - 1)]
                                      + $urandom_range(2) - 1));
            else
                push_query(clamp_word(span_lo - 64
                                      + int'($urandom_range(span_hi - span_lo + 128))));
        end
    endtask

    task automatic run_phase(int piu, int below, int above, int lo, int hi,
                             bit extreme_y, int count);
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(REG_POINTS_IN_USE, piu);
        write_reg(REG_BELOW_VALUE, below);
        write_reg(REG_ABOVE_VALUE, above);
        build_table((piu < TABLE_DEPTH) ? piu : TABLE_DEPTH, lo, hi, extreme_y);
        mix_beats(count / 2);
        drain();
        mix_beats(count - count / 2);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        out_ready   = 1'b0;
        action      = ACT_LOAD;
        point_index = '0;
        point_x     = '0;
        point_y     = '0;
        query_value = '0;
        cfg_we      = 1'b0;
        cfg_index   = REG_POINTS_IN_USE;
        cfg_wdata   = '0;
        points_cfg  = '0;
        below_cfg   = '0;
        above_cfg   = '0;
        errors      = 0;
        cycles      = 0;
        steady      = 1'b0;
        in_fire     = 1'b0;
        points_live = 0;
        span_lo     = 0;
        span_hi     = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // empty table after reset, then fill every entry
        push_query(WORD_MIN);
        push_query(WORD_MAX);
        push_query(0);
        for (int i = 0; i < TABLE_DEPTH; i++)
            push_load(i, WORD_MIN + i * 1000, (i % 2) ? WORD_MAX : WORD_MIN);
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);

        write_reg(REG_UNUSED, 16'h5A5A);
        write_reg(REG_POINTS_IN_USE, 2);
        write_reg(REG_BELOW_VALUE, WORD_MIN);
        write_reg(REG_ABOVE_VALUE, WORD_MAX);
        push_load(0, WORD_MIN, WORD_MIN);
        push_load(1, WORD_MAX, WORD_MAX);
        push_query(WORD_MIN);
        push_query(WORD_MAX - 1);
        push_query(WORD_MAX);
        push_query(0);
        push_load(0, WORD_MIN, WORD_MAX);
        push_load(1, WORD_MAX, WORD_MIN);
        push_query(0);
        push_query(WORD_MAX - 1);
        push_load(0, -100, 5);
        push_load(1, -99, -7);
        push_query(-101);
        push_query(-100);
        push_query(-99);
        // unsorted pair: scan order alone decides
        push_load(1, -200, 3);
        push_query(-150);
        push_query(-50);
        // truncation toward zero on a falling segment
        push_load(0, 0, 0);
        push_load(1, 3, -1);
        push_query(1);
        push_query(2);

        run_phase(1, random_word(), random_word(), -1000, 1000, 1'b0, 120);
        run_phase(TABLE_DEPTH, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX, 1'b1, 220);
        run_phase(127, random_word(), random_word(), -2000, 2000, 1'b0, 200);
        drain();
        steady = 1'b1;
        run_phase(3, 0, -1, -10, 10, 1'b0, 200);
        drain();
        steady = 1'b0;
        run_phase(0, random_word(), WORD_MIN, -500, 500, 1'b0, 60);
        run_phase(16, random_word(), random_word(), -30000, 30000, 1'b0, 200);
        run_phase(100, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, 1'b0, 200);
        run_phase(40, random_word(), random_word(), -64, 64, 1'b0, 200);
        run_phase(8, random_word(), random_word(), WORD_MIN, WORD_MAX, 1'b1, 200);

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (expected_answers.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_answers.size()));
        $display("covered %0d loads and %0d queries over %0d cycles", loads_taken,
                 queries_taken, cycles);
        $display("answers: %0d interpolated, %0d below range, %0d beyond range",
                 region_hits[0], region_hits[1], region_hits[2]);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/tli_pkg.sv
rtl/tli_ram.sv
rtl/table_linear_interpolator.sv
sim/table_linear_interpolator_test.sv
